### rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### rtl/rau_pkg.sv
// Package with widths, operation codes and word types of the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;

   localparam int WIDTH  = 16;
   localparam int DEN_W  = WIDTH - 1;
   localparam int KIND_W = 3;
   localparam int PROD_W = 2 * WIDTH;
   localparam int SUM_W  = PROD_W + 1;
   localparam int MAG_W  = PROD_W;
   localparam int SH_W   = $clog2(MAG_W);

   localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CMP = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic signed [WIDTH-1:0] a_num;
      logic [DEN_W-1:0]        a_den;
      logic signed [WIDTH-1:0] b_num;
      logic [DEN_W-1:0]        b_den;
   } req_type;

   typedef struct packed {
      logic signed [WIDTH-1:0] res_num;
      logic [DEN_W-1:0]        res_den;
      logic                    less_than;
      logic                    equal_to;
      logic                    divide_by_zero;
      logic                    overflow;
   } rsp_type;

endpackage

### rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: sequencer, cross products, output register.
// A word passes the cross products, the exact fraction and its magnitudes, then the gcd and two
// restoring divisions of the reduction engine. Compare, error and zero results skip reduction.
// One word is in work at a time; the next is taken the cycle after the result loads.
// Reset is synchronous and active high; it idles the sequencers and empties the output.
`timescale 1ns / 1ps
module rational_arithmetic_unit import rau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Sequencer states. A word is captured in idle, its four products come from the
   // shared multiplier, the exact fraction is formed, its magnitudes are taken, the
   // reduction engine runs when needed, and the finished word waits for room in the output register.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL    = 3'd1;
   localparam logic [2:0] ST_FORM   = 3'd2;
   localparam logic [2:0] ST_ABS    = 3'd3;
   localparam logic [2:0] ST_REDUCE = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   localparam logic [MAG_W-1:0] LIM    = MAG_W'(1) << (WIDTH - 1);
   localparam logic [MAG_W-1:0] LIM_M1 = LIM - MAG_W'(1);

   logic [2:0]               state_ff, state_in;
   logic [2:0]               mcnt_ff, mcnt_in;
   req_type                  op_ff, op_in;
   logic signed [PROD_W-1:0] prod_ff [4];
   logic signed [PROD_W-1:0] prod_in [4];
   logic signed [SUM_W-1:0]  n_ff, n_in, d_ff, d_in;
   logic                     lt_ff, lt_in, eq_ff, eq_in;
   logic                     dz_ff, dz_in, arith_ff, arith_in;
   logic                     neg_ff, neg_in, zero_ff, zero_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic signed [WIDTH-1:0]  mul_a, mul_b, aden_x, bden_x;
   logic signed [PROD_W-1:0] mul_p;
   logic [1:0]               prod_idx;

   logic signed [SUM_W-1:0]  left_x, right_x, prod2_x, prod3_x, sum_n, sum_d;
   logic                     arith_k, dz_k;
   logic signed [SUM_W-1:0]  n_neg, d_neg;
   logic [MAG_W-1:0]         mag_n, mag_d;
   logic                     go;
   logic                     red_start, red_done;
   logic [MAG_W-1:0]         quo_num, quo_den;
   logic                     num_ovf, den_ovf, ovf;
   logic [WIDTH-1:0]         qn_lo, num_val;
   logic                     load;

   // Denominators are unsigned, so a zero top bit makes them nonnegative signed operands.
   assign aden_x = {1'b0, op_ff.a_den};
   assign bden_x = {1'b0, op_ff.b_den};

   // Product order: a_num*b_den, b_num*a_den, a_num*b_num, a_den*b_den.
   // The divide denominator a_den*b_num is the second product, so four are enough.
   always_comb begin
      unique case (mcnt_ff[1:0])
         2'd0: begin
            mul_a = op_ff.a_num;
            mul_b = bden_x;
         end
         2'd1: begin
            mul_a = op_ff.b_num;
            mul_b = aden_x;
         end
         2'd2: begin
            mul_a = op_ff.a_num;
            mul_b = op_ff.b_num;
         end
         default: begin
            mul_a = aden_x;
            mul_b = bden_x;
         end
      endcase
   end

   rau_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   // The multiplier product is registered, so it arrives in the cycle after its operand select.
   assign prod_idx = 2'(mcnt_ff - 3'd1);

   // Exact result before reduction, one bit wider than the products so a sum cannot wrap.
   assign left_x  = {prod_ff[0][PROD_W-1], prod_ff[0]};
   assign right_x = {prod_ff[1][PROD_W-1], prod_ff[1]};
   assign prod2_x = {prod_ff[2][PROD_W-1], prod_ff[2]};
   assign prod3_x = {prod_ff[3][PROD_W-1], prod_ff[3]};

   always_comb begin
      unique case (op_ff.kind)
         KIND_ADD: begin
            sum_n = left_x + right_x;
            sum_d = prod3_x;
         end
         KIND_SUB: begin
            sum_n = left_x - right_x;
            sum_d = prod3_x;
         end
         KIND_MUL: begin
            sum_n = prod2_x;
            sum_d = prod3_x;
         end
         KIND_DIV: begin
            sum_n = left_x;
            sum_d = right_x;
         end
         default: begin
            sum_n = '0;
            sum_d = SUM_W'(1);
         end
      endcase
   end

   // Compare and the unused codes produce flags only.
   assign arith_k = (op_ff.kind == KIND_ADD) || (op_ff.kind == KIND_SUB) ||
                    (op_ff.kind == KIND_MUL) || (op_ff.kind == KIND_DIV);

   // A zero operand denominator, or dividing by a zero fraction, leaves no defined value.
   assign dz_k = arith_k && ((op_ff.a_den == '0) || (op_ff.b_den == '0) ||
                 ((op_ff.kind == KIND_DIV) && (op_ff.b_num == '0)));

   // Magnitudes; the sign of the result goes to the numerator.
   assign n_neg = -n_ff;
   assign d_neg = -d_ff;
   assign mag_n = n_ff[SUM_W-1] ? n_neg[MAG_W-1:0] : n_ff[MAG_W-1:0];
   assign mag_d = d_ff[SUM_W-1] ? d_neg[MAG_W-1:0] : d_ff[MAG_W-1:0];

   // Only a defined, nonzero arithmetic result needs the gcd and the divisions.
   assign go        = arith_ff && !dz_ff && (mag_n != '0);
   assign red_start = (state_ff == ST_ABS) && go;

   rau_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .start   (red_start),
      .num_mag (mag_n),
      .den_mag (mag_d),
      .done    (red_done),
      .quo_num (quo_num),
      .quo_den (quo_den)
   );

   // Range check of the reduced terms. A negative numerator may reach one further.
   assign den_ovf = quo_den > LIM_M1;
   assign num_ovf = neg_ff ? (quo_num > LIM) : (quo_num > LIM_M1);
   assign ovf     = !zero_ff && (den_ovf || num_ovf);
   assign qn_lo   = quo_num[WIDTH-1:0];
   assign num_val = neg_ff ? -qn_lo : qn_lo;

   always_comb begin
      rsp_data_in.less_than      = lt_ff;
      rsp_data_in.equal_to       = eq_ff;
      rsp_data_in.divide_by_zero = dz_ff;
      rsp_data_in.overflow       = ovf;
      if (zero_ff || ovf) begin
         rsp_data_in.res_num = '0;
         rsp_data_in.res_den = DEN_W'(1);
      end else begin
         rsp_data_in.res_num = num_val;
         rsp_data_in.res_den = quo_den[DEN_W-1:0];
      end
   end

   // The finished word moves into the output register once that register is free or
   // is being emptied in the same cycle.
   assign load = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      priority if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Main sequencer.
   always_comb begin
      state_in = state_ff;
      mcnt_in  = mcnt_ff;
      op_in    = op_ff;
      prod_in  = prod_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      dz_in    = dz_ff;
      arith_in = arith_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_data;
               mcnt_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mcnt_ff != 3'd0) begin
               prod_in[prod_idx] = mul_p;
            end
            mcnt_in = mcnt_ff + 3'd1;
            if (mcnt_ff == 3'd4) begin
               state_in = ST_FORM;
            end
         end
         ST_FORM: begin
            n_in     = sum_n;
            d_in     = sum_d;
            lt_in    = prod_ff[0] < prod_ff[1];
            eq_in    = prod_ff[0] == prod_ff[1];
            dz_in    = dz_k;
            arith_in = arith_k;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            neg_in   = n_ff[SUM_W-1] ^ d_ff[SUM_W-1];
            zero_in  = !go;
            state_in = go ? ST_REDUCE : ST_FINISH;
         end
         ST_REDUCE: begin
            if (red_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mcnt_ff      <= mcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      prod_ff  <= prod_in;
      n_ff     <= n_in;
      d_ff     <= d_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
      dz_ff    <= dz_in;
      arith_ff <= arith_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A new word is taken only while the sequencer is idle.
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/rau_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module rau_mul import rau_pkg::*; (
   input  logic                     clock,
   input  logic signed [WIDTH-1:0]  mul_a,
   input  logic signed [WIDTH-1:0]  mul_b,
   output logic signed [PROD_W-1:0] mul_p
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

### rtl/rau_reduce.sv
// Reduction engine: binary gcd and two restoring divisions on one shared subtractor.
`timescale 1ns / 1ps
module rau_reduce import rau_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] num_mag,
   input  logic [MAG_W-1:0] den_mag,
   output logic             done,
   output logic [MAG_W-1:0] quo_num,
   output logic [MAG_W-1:0] quo_den
);

   localparam logic [1:0] R_IDLE = 2'd0;
   localparam logic [1:0] R_GCD  = 2'd1;
   localparam logic [1:0] R_DIV  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic             done_ff, done_in;
   logic [MAG_W-1:0] u_ff, u_in, v_ff, v_in;
   logic [SH_W-1:0]  k_ff, k_in;
   logic [MAG_W-1:0] xd_ff, xd_in;
   logic [MAG_W-1:0] g_ff, g_in;
   logic [MAG_W-1:0] rem_ff, rem_in;
   logic [MAG_W-1:0] quo_ff, quo_in;
   logic [SH_W-1:0]  cnt_ff, cnt_in;
   logic             sel_ff, sel_in;
   logic [MAG_W-1:0] qn_ff, qn_in, qd_ff, qd_in;

   logic [MAG_W:0]   sub_a, sub_b, sub_y;
   logic             sub_neg;
   logic [MAG_W-1:0] quo_next;

   // The one subtractor: gcd compare/subtract or a division trial step.
   always_comb begin
      if (state_ff == R_DIV) begin
         sub_a = {rem_ff, quo_ff[MAG_W-1]};
         sub_b = {1'b0, g_ff};
      end else begin
         sub_a = {1'b0, v_ff};
         sub_b = {1'b0, u_ff};
      end
   end

   assign sub_y    = sub_a - sub_b;
   assign sub_neg  = sub_y[MAG_W];
   assign quo_next = {quo_ff[MAG_W-2:0], ~sub_neg};

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      u_in     = u_ff;
      v_in     = v_ff;
      k_in     = k_ff;
      xd_in    = xd_ff;
      g_in     = g_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      qn_in    = qn_ff;
      qd_in    = qd_ff;
      unique case (state_ff)
         R_IDLE: begin
            if (start) begin
               u_in     = num_mag;
               v_in     = den_mag;
               k_in     = '0;
               quo_in   = num_mag;
               xd_in    = den_mag;
               state_in = R_GCD;
            end
         end
         R_GCD: begin
            priority if (v_ff == '0) begin
               g_in     = u_ff << k_ff;
               rem_in   = '0;
               cnt_in   = '0;
               sel_in   = 1'b0;
               state_in = R_DIV;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + SH_W'(1);
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (sub_neg) begin
               u_in = v_ff;
               v_in = u_ff;
            end else begin
               v_in = sub_y[MAG_W-1:0];
            end
         end
         R_DIV: begin
            rem_in = sub_neg ? sub_a[MAG_W-1:0] : sub_y[MAG_W-1:0];
            quo_in = quo_next;
            cnt_in = cnt_ff + SH_W'(1);
            if (cnt_ff == SH_W'(MAG_W - 1)) begin
               cnt_in = '0;
               rem_in = '0;
               if (!sel_ff) begin
                  qn_in  = quo_next;
                  quo_in = xd_ff;
                  sel_in = 1'b1;
               end else begin
                  qd_in    = quo_next;
                  done_in  = 1'b1;
                  state_in = R_IDLE;
               end
            end
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff   <= u_in;
      v_ff   <= v_in;
      k_ff   <= k_in;
      xd_ff  <= xd_in;
      g_ff   <= g_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      sel_ff <= sel_in;
      qn_ff  <= qn_in;
      qd_ff  <= qd_in;
   end

   assign done    = done_ff;
   assign quo_num = qn_ff;
   assign quo_den = qd_ff;

endmodule

### rtl/rau_checker.sv
// Port-level checker for the rational arithmetic unit and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rau_checker import rau_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic rsp_held;
   logic req_taken;
   logic rsp_flagged;
   logic rsp_zero;

   assign rsp_held    = rsp_valid && rsp_stall;
   assign req_taken   = req_valid && !req_stall;
   assign rsp_flagged = rsp_valid && (rsp_data.divide_by_zero || rsp_data.overflow);
   assign rsp_zero    = (rsp_data.res_num == '0) && (rsp_data.res_den == DEN_W'(1));

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_taken, req_stall)
   `ASSERT_IMPLY(a_flag_gives_zero, clock, reset, rsp_flagged, rsp_zero)
   `ASSERT_IMPLY(a_den_positive, clock, reset, rsp_valid, rsp_data.res_den != '0)
   `ASSERT_IMPLY(a_eq_not_lt, clock, reset, rsp_valid && rsp_data.equal_to, !rsp_data.less_than)

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
